// ===== rtl/graph_clique_checker_core_macros.svh =====
// Assertion macros shared by the clique checker RTL.
`ifndef GRAPH_CLIQUE_CHECKER_CORE_MACROS_SVH
`define GRAPH_CLIQUE_CHECKER_CORE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define GCC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define GCC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gcc_pkg.sv =====
// Shared constants and types for the clique checker.
package gcc_pkg;

    localparam int DEF_MAX_VERTICES = 256;
    localparam int DEF_MAX_MEMBERS  = 256;

    localparam int VERTEX_W   = 9;
    localparam int MEMBER_W   = 8;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 8;

    localparam logic FUNC_ADD_EDGE = 1'b0;
    localparam logic FUNC_MEMBER   = 1'b1;

    typedef struct packed {
        logic [VERTEX_W-1:0] row;
        logic [VERTEX_W-1:0] col;
    } pair_req_t;

endpackage

// ===== rtl/gcc_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module gcc_ram
    import gcc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/gcc_pair_unit.sv =====
// Shared pair unit: range check and matrix address for a vertex pair.
module gcc_pair_unit
    import gcc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
)
(
    input  pair_req_t                                      req,
    output logic                                           hit,
    output logic [$clog2(MAX_VERTICES*MAX_VERTICES)-1:0]   addr
);

    localparam int ADJ_AW = $clog2(MAX_VERTICES * MAX_VERTICES);
    localparam int PW     = ADJ_AW + VERTEX_W;

    logic [PW-1:0] lin;

    assign lin  = PW'(req.row) * PW'(MAX_VERTICES) + PW'(req.col);
    assign addr = lin[ADJ_AW-1:0];
    assign hit  = (32'(req.row) < MAX_VERTICES) && (32'(req.col) < MAX_VERTICES);

endmodule

// ===== rtl/graph_clique_checker_core.sv =====
// Clique checker top level: sequencer, adjacency matrix and member list.
// Edge item: accept, then one matrix write per mirrored bit; no write if an endpoint is 0.
// Member item: stored in the member list. Last member: a walk over the P = N*(N-1)/2 pairs
// of the N stored members, one matrix read per pair; a failing pair ends the walk early.
// Reset clears the adjacency matrix one bit per cycle; no item is taken meanwhile.
`include "graph_clique_checker_core_macros.svh"

module graph_clique_checker_core
    import gcc_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int MAX_MEMBERS  = DEF_MAX_MEMBERS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // vertex_a[8:0], vertex_b[17:9], member[25:18]
    input  logic                  s_tlast,   // last_member
    input  logic                  s_tuser,   // func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // is_clique[0], overflow[1]
);

    localparam int ADJ_DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int ADJ_AW    = $clog2(ADJ_DEPTH);
    localparam int MEM_AW    = $clog2(MAX_MEMBERS);
    localparam int CNT_W     = $clog2(MAX_MEMBERS + 1);

    typedef enum logic [10:0] {
        ST_CLEAR    = 11'b00000000001,
        ST_IDLE     = 11'b00000000010,
        ST_EDGE1    = 11'b00000000100,
        ST_EDGE2    = 11'b00000001000,
        ST_RD_I     = 11'b00000010000,
        ST_WAIT_I   = 11'b00000100000,
        ST_RD_J     = 11'b00001000000,
        ST_WAIT_J   = 11'b00010000000,
        ST_ADJ      = 11'b00100000000,
        ST_ADJ_WAIT = 11'b01000000000,
        ST_REPORT   = 11'b10000000000
    } state_t;

    state_t              state_reg, state_next;
    logic [ADJ_AW-1:0]   clr_reg, clr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [CNT_W-1:0]    i_reg, i_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    logic [VERTEX_W-1:0] row_reg, row_next;
    logic [VERTEX_W-1:0] col_reg, col_next;
    logic                hit_reg, hit_next;
    logic                pass_reg, pass_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_clique_reg, out_clique_next;
    logic                out_ovf_reg, out_ovf_next;

    logic [VERTEX_W-1:0] in_a;
    logic [VERTEX_W-1:0] in_b;
    logic [MEMBER_W-1:0] in_m;
    logic                accept;

    pair_req_t           pair_req;
    logic                pair_hit;
    logic [ADJ_AW-1:0]   pair_addr;

    logic                adj_we;
    logic [ADJ_AW-1:0]   adj_waddr;
    logic                adj_wdata;
    logic                adj_rdata;

    logic                mem_we;
    logic [MEM_AW-1:0]   mem_raddr;
    logic [MEMBER_W-1:0] mem_rdata;

    assign in_a     = s_tdata[VERTEX_W-1:0];
    assign in_b     = s_tdata[2*VERTEX_W-1:VERTEX_W];
    assign in_m     = s_tdata[2*VERTEX_W+MEMBER_W-1:2*VERTEX_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-2){1'b0}}, out_ovf_reg, out_clique_reg};

    assign pair_req.row = (state_reg == ST_EDGE2) ? col_reg : row_reg;
    assign pair_req.col = (state_reg == ST_EDGE2) ? row_reg : col_reg;

    gcc_pair_unit #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_pair (
        .req  (pair_req),
        .hit  (pair_hit),
        .addr (pair_addr)
    );

    gcc_ram #(
        .WIDTH (1),
        .DEPTH (ADJ_DEPTH)
    ) u_adj_ram (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata (adj_wdata),
        .raddr (pair_addr),
        .rdata (adj_rdata)
    );

    assign mem_we    = accept && (s_tuser == FUNC_MEMBER) && (count_reg < CNT_W'(MAX_MEMBERS));
    assign mem_raddr = (state_reg == ST_RD_I) ? i_reg[MEM_AW-1:0] : j_reg[MEM_AW-1:0];

    gcc_ram #(
        .WIDTH (MEMBER_W),
        .DEPTH (MAX_MEMBERS)
    ) u_member_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[MEM_AW-1:0]),
        .wdata (in_m),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        hit_next        = hit_reg;
        pass_next       = pass_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_clique_next = out_clique_reg;
        out_ovf_next    = out_ovf_reg;
        adj_we          = 1'b0;
        adj_waddr       = pair_addr;
        adj_wdata       = 1'b1;

        case (state_reg)
            ST_CLEAR:
            begin
                adj_we    = 1'b1;
                adj_waddr = clr_reg;
                adj_wdata = 1'b0;
                if (clr_reg == ADJ_AW'(ADJ_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == FUNC_ADD_EDGE)
                    begin
                        row_next = in_a - 1'b1;
                        col_next = in_b - 1'b1;
                        if ((in_a != '0) && (in_b != '0))
                        begin
                            state_next = ST_EDGE1;
                        end
                    end
                    else
                    begin
                        if (mem_we)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (s_tlast)
                        begin
                            i_next     = '0;
                            pass_next  = 1'b1;
                            state_next = ST_RD_I;
                        end
                    end
                end
            end
            ST_EDGE1:
            begin
                adj_we     = pair_hit;
                state_next = ST_EDGE2;
            end
            ST_EDGE2:
            begin
                adj_we     = pair_hit;
                state_next = ST_IDLE;
            end
            ST_RD_I:
            begin
                if (CNT_W'(i_reg + 1'b1) >= count_reg)
                begin
                    state_next = ST_REPORT;
                end
                else
                begin
                    state_next = ST_WAIT_I;
                end
            end
            ST_WAIT_I:
            begin
                row_next   = VERTEX_W'(mem_rdata);
                j_next     = i_reg + 1'b1;
                state_next = ST_RD_J;
            end
            ST_RD_J:
            begin
                state_next = ST_WAIT_J;
            end
            ST_WAIT_J:
            begin
                col_next   = VERTEX_W'(mem_rdata);
                state_next = ST_ADJ;
            end
            ST_ADJ:
            begin
                hit_next   = pair_hit;
                state_next = ST_ADJ_WAIT;
            end
            ST_ADJ_WAIT:
            begin
                if (!(hit_reg && adj_rdata))
                begin
                    pass_next  = 1'b0;
                    state_next = ST_REPORT;
                end
                else if (CNT_W'(j_reg + 1'b1) < count_reg)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_RD_J;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_RD_I;
                end
            end
            ST_REPORT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_clique_next = pass_reg;
                    out_ovf_next    = ovf_reg;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        hit_reg        <= hit_next;
        pass_reg       <= pass_next;
        out_clique_reg <= out_clique_next;
        out_ovf_reg    <= out_ovf_next;
    end

    `GCC_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(MAX_MEMBERS), "member count over limit")
    `GCC_ASSERT_IMPLY(a_ovf_full, ovf_reg, count_reg == CNT_W'(MAX_MEMBERS),
        "overflow while list not full")
    `GCC_ASSERT_IMPLY(a_pair_order, state_reg == ST_RD_J,
        (j_reg > i_reg) && (j_reg < count_reg), "pair index out of order")
    `GCC_ASSERT_IMPLY(a_out_from_report, $rose(out_valid_reg), $past(state_reg == ST_REPORT),
        "result without a check")

endmodule
